FILE: rtl/stps_pkg.sv
// Shared types and constants for the slide transition pixel source.
// Frame geometry, field widths, register and direction codes, payload structs.
// No dependencies; every other file imports this package.
package stps_pkg;

    // Frame geometry
    localparam int FRAME_WIDTH  = 320;
    localparam int FRAME_HEIGHT = 240;

    // Field widths
    localparam int COL_W      = 9;
    localparam int ROW_W      = 8;
    localparam int ADDR_W     = 17;
    localparam int OFS_W      = 9;
    localparam int DIR_W      = 3;
    localparam int CFG_DATA_W = 9;
    localparam int CFG_IDX_W  = 2;

    // Working width: holds any sum of a coordinate, an offset and an extent
    localparam int CALC_W = $clog2((2 ** COL_W) + (2 ** OFS_W) + FRAME_WIDTH + FRAME_HEIGHT);

    // Slide direction codes
    typedef enum logic [DIR_W-1:0] {
        DIR_NONE  = 3'd0,
        DIR_RIGHT = 3'd1,
        DIR_LEFT  = 3'd2,
        DIR_UP    = 3'd3,
        DIR_DOWN  = 3'd4
    } dir_t;

    // Configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_OFFSET    = 2'd0,
        CFG_DIRECTION = 2'd1,
        CFG_PRESENT   = 2'd2,
        CFG_HALF_RES  = 2'd3
    } cfg_index_t;

    // Current configuration, as seen by the mapping logic
    typedef struct packed {
        logic [OFS_W-1:0] slide_offset;
        logic [DIR_W-1:0] slide_direction;
        logic             second_present;
        logic             second_half_res;
    } cfg_t;

    // Input transaction
    typedef struct packed {
        logic [COL_W-1:0] pixel_column;
        logic [ROW_W-1:0] pixel_row;
    } pixel_t;

    // Result transaction
    typedef struct packed {
        logic              take_second;
        logic [COL_W-1:0]  source_column;
        logic [ROW_W-1:0]  source_row;
        logic [ADDR_W-1:0] source_address;
    } result_t;

endpackage

FILE: rtl/stps_cfg.sv
// Configuration register file for the slide transition pixel source.
// Depends on stps_pkg for widths, register indexes and cfg_t.
module stps_cfg (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               cfg_write,
    input  logic [stps_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [stps_pkg::CFG_DATA_W-1:0]    cfg_data,
    output stps_pkg::cfg_t                     cfg
);
    import stps_pkg::*;

    cfg_t cfg_reg;
    cfg_t cfg_next;

    // Decode the write into the addressed register
    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_write)
        begin
            case (cfg_index_t'(cfg_index))
                CFG_OFFSET:    cfg_next.slide_offset    = cfg_data[OFS_W-1:0];
                CFG_DIRECTION: cfg_next.slide_direction = cfg_data[DIR_W-1:0];
                CFG_PRESENT:   cfg_next.second_present  = cfg_data[0];
                CFG_HALF_RES:  cfg_next.second_half_res = cfg_data[0];
                default:       cfg_next = cfg_reg;
            endcase
        end
    end

    // Hold the registers; reset clears all of them
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= '0;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

FILE: rtl/stps_map.sv
// Combinational pixel source mapping: picks the image, shifts the coordinate
// along the slide axis, halves for a half-res source and forms the address.
// Depends on stps_pkg for geometry, direction codes and payload structs.
module stps_map (
    input  stps_pkg::cfg_t     cfg,
    input  stps_pkg::pixel_t   pixel,
    output stps_pkg::result_t  result
);
    import stps_pkg::*;

    localparam logic [CALC_W-1:0] W_C = CALC_W'(FRAME_WIDTH);
    localparam logic [CALC_W-1:0] H_C = CALC_W'(FRAME_HEIGHT);
    localparam int FULL_STRIDE = FRAME_WIDTH;
    localparam int HALF_STRIDE = FRAME_WIDTH / 2;
    localparam int PROD_W      = CALC_W + $clog2(FRAME_WIDTH + 1) + 1;

    logic [CALC_W-1:0] x;
    logic [CALC_W-1:0] y;
    logic [CALC_W-1:0] ofs;
    logic [CALC_W-1:0] pv;
    logic [CALC_W-1:0] ph;
    logic [CALC_W-1:0] thr_v;
    logic [CALC_W-1:0] thr_h;
    logic              passthru;
    logic              sec;
    logic              halve;
    logic [CALC_W-1:0] col;
    logic [CALC_W-1:0] row;
    logic [CALC_W-1:0] col_s;
    logic [CALC_W-1:0] row_s;
    logic [PROD_W-1:0] addr_full;

    // Saturate the offset per axis and find the split point
    always_comb
    begin
        x     = CALC_W'(pixel.pixel_column);
        y     = CALC_W'(pixel.pixel_row);
        ofs   = CALC_W'(cfg.slide_offset);
        pv    = (ofs > H_C) ? H_C : ofs;
        ph    = (ofs > W_C) ? W_C : ofs;
        thr_v = H_C - pv;
        thr_h = W_C - ph;
        passthru = !cfg.second_present || (cfg.slide_offset == '0);
    end

    // Choose the source image and shift the coordinate
    always_comb
    begin
        sec = 1'b0;
        col = x;
        row = y;
        if (!passthru)
        begin
            case (dir_t'(cfg.slide_direction))
                DIR_UP:
                begin
                    if (y >= thr_v)
                    begin
                        sec = 1'b1;
                        row = y - thr_v;
                    end
                    else
                    begin
                        row = y + pv;
                    end
                end
                DIR_DOWN:
                begin
                    if (y < pv)
                    begin
                        sec = 1'b1;
                        row = thr_v + y;
                    end
                    else
                    begin
                        row = y - pv;
                    end
                end
                DIR_RIGHT:
                begin
                    if (x >= thr_h)
                    begin
                        sec = 1'b1;
                        col = x - thr_h;
                    end
                    else
                    begin
                        col = x + ph;
                    end
                end
                DIR_LEFT:
                begin
                    if (x < ph)
                    begin
                        sec = 1'b1;
                        col = thr_h + x;
                    end
                    else
                    begin
                        col = x - ph;
                    end
                end
                default:
                begin
                    sec = 1'b0;
                end
            endcase
        end
    end

    // Halve for a half-res incoming image and form the linear address
    always_comb
    begin
        halve = sec && cfg.second_half_res;
        col_s = halve ? (col >> 1) : col;
        row_s = halve ? (row >> 1) : row;
        if (halve)
        begin
            addr_full = PROD_W'(row_s) * PROD_W'(HALF_STRIDE) + PROD_W'(col_s);
        end
        else
        begin
            addr_full = PROD_W'(row_s) * PROD_W'(FULL_STRIDE) + PROD_W'(col_s);
        end
        result.take_second    = sec;
        result.source_column  = col_s[COL_W-1:0];
        result.source_row     = row_s[ROW_W-1:0];
        result.source_address = addr_full[ADDR_W-1:0];
    end

endmodule

FILE: rtl/slide_transition_pixel_source.sv
// Top level of the slide transition pixel source: input register, mapping
// logic, result register and configuration registers.
// Depends on stps_pkg, stps_cfg and stps_map.
//
//   channel   ports                                   handshake
//   -------   -------------------------------------   ---------------------------
//   config    cfg_write, cfg_index, cfg_data          write when cfg_write high
//   input     start, busy, pixel                      taken when start && !busy
//   result    done, result                            one cycle strobe, no stall
//
// One pixel per clock, sustained. A pixel taken is held in the input register,
// mapped from there and its result loaded into the result register, marked
// by done. The path between the two registers saturates the offset, compares
// against the split point, adds or subtracts, may halve and does a
// constant-stride multiply-add. busy stays low. Reset clears the valid flags
// and every configuration register; payload registers are not reset.
module slide_transition_pixel_source (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               cfg_write,
    input  logic [stps_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [stps_pkg::CFG_DATA_W-1:0]    cfg_data,
    input  logic                               start,
    output logic                               busy,
    input  stps_pkg::pixel_t                   pixel,
    output logic                               done,
    output stps_pkg::result_t                  result
);
    import stps_pkg::*;

    cfg_t    cfg;
    logic    accept;
    logic    in_valid_reg;
    logic    in_valid_next;
    pixel_t  in_reg;
    result_t map_result;
    logic    result_valid_reg;
    logic    result_valid_next;
    result_t result_reg;

    // Configuration registers
    stps_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    // Never stall the source: a new transaction fits every cycle
    assign busy   = 1'b0;
    assign accept = start && !busy;

    // Advance the valid flags
    always_comb
    begin
        in_valid_next     = accept;
        result_valid_next = in_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg     <= 1'b0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg     <= in_valid_next;
            result_valid_reg <= result_valid_next;
        end
    end

    // Capture the input transaction
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            in_reg <= pixel;
        end
    end

    // Map the held pixel to its source
    stps_map u_map (
        .cfg    (cfg),
        .pixel  (in_reg),
        .result (map_result)
    );

    // Register the result transaction
    always_ff @(posedge clk)
    begin
        if (in_valid_reg)
        begin
            result_reg <= map_result;
        end
    end

    assign done   = result_valid_reg;
    assign result = result_reg;

`ifndef SYNTH
    a_accept_loads: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> in_valid_reg)
        else $error("accepted transaction did not reach the input register");

    a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid_reg |=> done)
        else $error("held pixel did not produce a result");

    a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
        !in_valid_reg |=> !done)
        else $error("result strobe without a held pixel");

    a_no_second: assert property (@(posedge clk) disable iff (!rst_n)
        done && !$past(cfg.second_present) |-> !result.take_second)
        else $error("incoming image chosen while none is present");
`endif

endmodule
